>>> rtl/fold_mix_byte_hash_64_defines.svh
// Assertion macros for the fold/mix byte hash.
// Expects a clock named clock and an active-high reset named reset in scope.
`ifndef FOLD_MIX_BYTE_HASH_64_DEFINES_SVH
`define FOLD_MIX_BYTE_HASH_64_DEFINES_SVH
`ifndef SYNTHESIS
`define FMBH_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define FMBH_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define FMBH_ASSERT(lbl, prop, msg)
`define FMBH_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/fmbh_pkg.sv
// Shared constants and control structs for the fold/mix byte hash.
// No dependencies.
package fmbh_pkg;

   localparam int STORE_BYTES  = 32;
   localparam int IDX_W        = $clog2(STORE_BYTES);
   localparam int TAP_A        = 10;
   localparam int TAP_B        = 7;
   localparam int ROUNDS       = 3;
   localparam int RND_W        = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
   localparam int FIX_BYTE     = 4;
   localparam int FORCE_BYTE   = 2;
   localparam int DIGEST_BYTES = 8;
   localparam int DIGEST_W     = 8 * DIGEST_BYTES;

   localparam logic [7:0] FIX_MASK    = 8'h7a;
   localparam logic [7:0] FORCE_VALUE = 8'h22;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

   typedef struct packed {
      cell_ctl_type cells;
      logic         fold;
      logic         mix;
      logic         round_start;
      logic         load_out;
   } ring_ctl_type;

endpackage

>>> rtl/fold_mix_byte_hash_64.sv
// Fold/mix byte hash, 64-bit digest.
// Each accepted valid byte folds into the ring; a last item starts a realign of the ring, then
// ROUNDS mix rounds over the 32 store bytes and a hand-off. Throughput: one byte per cycle,
// set by the single ring rotation per cycle; input stalls through realign, mix and hand-off,
// longer while a digest waits. Sync reset clears all but the digest register.
// Depends on fmbh_pkg, fmbh_cell, fmbh_ctrl.
module fold_mix_byte_hash_64
   import fmbh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_byte_valid,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [DIGEST_W-1:0] rsp_digest
);

   ring_ctl_type        ctl;
   logic [7:0]          cell_q [STORE_BYTES];
   logic [7:0]          shift_d [STORE_BYTES];
   logic [7:0]          head_next;
   logic [7:0]          a_sh;
   logic [7:0]          b_sh;
   logic [15:0]         prod_full;
   logic [7:0]          sum;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DIGEST_W-1:0] rsp_digest_ff, rsp_digest_in;
   logic                out_busy;

   assign out_busy = rsp_valid_ff && rsp_stall;

   fmbh_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_byte_valid (req_byte_valid),
      .req_last       (req_last),
      .req_stall      (req_stall),
      .out_busy       (out_busy),
      .ctl            (ctl)
   );

   // head update: fold a byte or run one mix step on the head byte
   always_comb begin
      a_sh      = {cell_q[TAP_A][3:0], 4'b0000};
      b_sh      = {1'b0, cell_q[TAP_B][7:1]};
      prod_full = a_sh * b_sh;
      sum       = cell_q[0] + prod_full[7:0];
      head_next = cell_q[0];
      if (ctl.fold) begin
         head_next = cell_q[0] ^ req_data_byte;
      end else if (ctl.mix) begin
         head_next = sum ^ {3'b000, sum[7:3]};
      end
   end

   always_comb begin
      for (int k = 0; k < STORE_BYTES - 1; k++) begin
         shift_d[k] = cell_q[k + 1];
      end
      shift_d[STORE_BYTES - 1] = head_next;
      if (ctl.round_start) begin
         shift_d[FIX_BYTE - 1] = ~(cell_q[FIX_BYTE] & FIX_MASK);
      end
   end

   for (genvar g = 0; g < STORE_BYTES; g++) begin : g_ring
      fmbh_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl.cells),
         .shift_in (shift_d[g]),
         .value    (cell_q[g])
      );
   end

   always_comb begin
      for (int k = 0; k < DIGEST_BYTES; k++) begin
         rsp_digest_in[DIGEST_W - 1 - 8 * k -: 8] = cell_q[k];
      end
      rsp_digest_in[DIGEST_W - 1 - 8 * FORCE_BYTE -: 8] = FORCE_VALUE;
   end

   assign rsp_valid_in = ctl.load_out || out_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the digest until the transfer completes
   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         rsp_digest_ff <= rsp_digest_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_digest = rsp_digest_ff;

endmodule

>>> rtl/fmbh_cell.sv
// One byte cell of the rotating store ring.
// Depends on fmbh_pkg.
module fmbh_cell
   import fmbh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic [7:0]   shift_in,
   output logic [7:0]   value
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (ctl.clear) begin
         byte_in = '0;
      end else if (ctl.shift) begin
         byte_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign value = byte_ff;

endmodule

>>> rtl/fmbh_ctrl.sv
// Sequencer for the hash ring: fold, realign, mix rounds, hand off digest.
// Depends on fmbh_pkg and fold_mix_byte_hash_64_defines.svh.
`include "fold_mix_byte_hash_64_defines.svh"
module fmbh_ctrl
   import fmbh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_byte_valid,
   input  logic         req_last,
   output logic         req_stall,
   input  logic         out_busy,
   output ring_ctl_type ctl
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ALIGN = 4'b0010,
      ST_MIX   = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic [RND_W-1:0] rnd_ff, rnd_in;
   logic             accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      step_in  = step_ff;
      rnd_in   = rnd_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_byte_valid) begin
                  ctl.fold        = 1'b1;
                  ctl.cells.shift = 1'b1;
                  pos_in          = pos_ff + 1'b1;
               end
               if (req_last) begin
                  state_in = ST_ALIGN;
               end
            end
         end
         ST_ALIGN: begin
            // rotate until store byte 0 sits in the head cell
            if (pos_ff == '0) begin
               state_in = ST_MIX;
               step_in  = '0;
               rnd_in   = '0;
            end else begin
               ctl.cells.shift = 1'b1;
               pos_in          = pos_ff + 1'b1;
            end
         end
         ST_MIX: begin
            ctl.cells.shift = 1'b1;
            ctl.mix         = 1'b1;
            ctl.round_start = (step_ff == '0);
            step_in         = step_ff + 1'b1;
            if (step_ff == IDX_W'(STORE_BYTES - 1)) begin
               if (rnd_ff == RND_W'(ROUNDS - 1)) begin
                  state_in = ST_DONE;
               end else begin
                  rnd_in = rnd_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (!out_busy) begin
               ctl.load_out    = 1'b1;
               ctl.cells.clear = 1'b1;
               pos_in          = '0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         step_ff  <= '0;
         rnd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         step_ff  <= step_in;
         rnd_ff   <= rnd_in;
      end
   end

   // full rounds rotate the ring back onto itself
   `FMBH_ASSERT(a_mix_aligned, (state_ff == ST_MIX) |-> (pos_ff == '0), "ring misaligned in mix")
   `FMBH_ASSERT(a_load_free, ctl.load_out |-> !out_busy, "digest loaded over pending transfer")
   `FMBH_ASSERT(a_idle_pos, (state_ff == ST_IDLE && !(accept && req_byte_valid)) |=> $stable(pos_ff), "position moved without a fold")

endmodule
